// ===== sv/bvse_pkg.sv =====
// shared types, constants and helper functions of the bit vector scan engine
`default_nettype none

package bvse_pkg;

  // default store size and fixed field widths
  localparam int MAX_BITS_DEF = 4096;
  localparam int WORD_BITS    = 32;
  localparam int OFF_W        = 5;
  localparam int POS_W        = 13;
  localparam int CMD_W        = 3;
  localparam int CNT_W        = 6;
  localparam int ERR_W        = 2;
  localparam int IN_DATA_W    = 64;
  localparam int OUT_DATA_W   = 32;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_NEXT_SET   = 3'd0,
    CMD_NEXT_CLEAR = 3'd1,
    CMD_SET_RANGE  = 3'd2,
    CMD_TEST_RANGE = 3'd3,
    CMD_APPEND     = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_t;

  // error codes
  typedef enum logic [ERR_W-1:0] {
    ERR_OK       = 2'd0,
    ERR_ORDER    = 2'd1,
    ERR_CAPACITY = 2'd2
  } err_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_WALK,
    ST_FOUND,
    ST_CLEAR,
    ST_DONE
  } state_t;

  // bit order reversal of one word
  function automatic logic [WORD_BITS-1:0] reverse_word(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] r;
    for (int i = 0; i < WORD_BITS; i++) begin
      r[i] = v[WORD_BITS-1-i];
    end
    return r;
  endfunction

  // index of the lowest set bit, zero for an empty word
  function automatic logic [OFF_W-1:0] low_zero_count(input logic [WORD_BITS-1:0] v);
    logic [OFF_W-1:0] n;
    n = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        n = OFF_W'(i);
      end
    end
    return n;
  endfunction

  // ones from bit lo up to bit hi inclusive
  function automatic logic [WORD_BITS-1:0] span_mask(input logic [OFF_W-1:0] lo,
                                                     input logic [OFF_W-1:0] hi);
    return ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (5'd31 - hi));
  endfunction

endpackage

`default_nettype wire

// ===== sv/bvse_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
`default_nettype none

module bvse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic                                     rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/bit_vector_scan_engine_unit.sv =====
// Bit vector scan engine: a bit store of up to MAX_BITS bits held in 32-bit words of one
// ram, with a current length. Commands arrive on the s_ stream, one at a time, and each
// gives one result on the m_ stream. Searches and range commands walk the stored words
// through one read-modify-write path, one word per cycle; search hits pass through
// ST_FOUND to form the bit index, append passes through ST_PREP first, and errors, empty
// ranges and searches past the length skip the walk. Clear sweeps every word. After reset
// the same sweep runs over all MAX_BITS/32 words (128 at the default size) before s_tready
// rises. MAX_BITS is expected to be a multiple of 32.
`default_nettype none

module bit_vector_scan_engine_unit #(
  parameter int MAX_BITS = bvse_pkg::MAX_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // command stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // position [12:0], range_end [25:13], data_word [57:26], bit_count [63:58]
  input  wire logic [bvse_pkg::IN_DATA_W-1:0]   s_tdata,
  // command [2:0]
  input  wire logic [bvse_pkg::CMD_W-1:0]       s_tuser,
  // result stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // found_index [12:0], range_match [13], error_code [15:14], bit_length [28:16], zeros above
  output logic      [bvse_pkg::OUT_DATA_W-1:0]  m_tdata
);

  import bvse_pkg::*;

  localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int IW        = AW + 1;
  localparam int LEN_W     = $clog2(MAX_BITS + 1);
  localparam int CW0       = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam int CW        = ((CW0 > IW + OFF_W) ? CW0 : IW + OFF_W) + 1;

  // sequencer state
  state_t state, state_next;

  // command registers
  logic [CMD_W-1:0]     op;
  logic [WORD_BITS-1:0] data_word;
  logic [LEN_W-1:0]     length;
  logic [IW-1:0]        first_idx;
  logic [IW-1:0]        last_idx;
  logic [OFF_W-1:0]     lo_bit;
  logic [OFF_W-1:0]     hi_bit;
  logic [OFF_W-1:0]     app_off;
  logic [WORD_BITS-1:0] rev_bits;
  logic [2*WORD_BITS-1:0] app_bits;

  // walk registers
  logic [IW-1:0]        rd_idx;
  logic                 rd_done;
  logic                 chk_valid;
  logic [IW-1:0]        chk_idx;
  logic [IW-1:0]        hit_idx;
  logic [WORD_BITS-1:0] hit_word;
  logic                 all_ok;
  logic [AW-1:0]        clr_idx;
  logic                 clr_reply;

  // result registers
  logic [POS_W-1:0]     res_found;
  logic                 res_match;
  logic [ERR_W-1:0]     res_err;
  logic                 out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  // ram ports
  logic                 ram_wr_en;
  logic [AW-1:0]        ram_wr_addr;
  logic [WORD_BITS-1:0] ram_wr_data;
  logic                 ram_rd_en;
  logic [WORD_BITS-1:0] ram_rd_data;

  // input fields
  logic [CMD_W-1:0]     in_cmd;
  logic [POS_W-1:0]     in_pos;
  logic [POS_W-1:0]     in_end;
  logic [WORD_BITS-1:0] in_data;
  logic [CNT_W-1:0]     in_cnt;
  logic                 accept;

  assign in_cmd  = s_tuser;
  assign in_pos  = s_tdata[12:0];
  assign in_end  = s_tdata[25:13];
  assign in_data = s_tdata[57:26];
  assign in_cnt  = s_tdata[63:58];
  assign accept  = s_tvalid && s_tready;

  // widened operands for compares
  logic [CW-1:0] pos_x, end_x, len_x, cnt_x, endm1_x, app_end_x, app_last_x;

  assign pos_x      = CW'(in_pos);
  assign end_x      = CW'(in_end);
  assign len_x      = CW'(length);
  assign cnt_x      = CW'(in_cnt);
  assign endm1_x    = end_x - CW'(1);
  assign app_end_x  = len_x + cnt_x;
  assign app_last_x = app_end_x - CW'(1);

  // command decode at transfer
  state_t           dec_state;
  logic [POS_W-1:0] dec_found;
  logic             dec_match;
  logic [ERR_W-1:0] dec_err;
  logic [IW-1:0]    dec_first;
  logic [IW-1:0]    dec_last;
  logic [OFF_W-1:0] dec_lo;
  logic [OFF_W-1:0] dec_hi;
  logic             dec_grow;

  always_comb begin
    dec_state = ST_DONE;
    dec_found = '0;
    dec_match = 1'b0;
    dec_err   = ERR_OK;
    dec_first = pos_x[IW+OFF_W-1:OFF_W];
    dec_last  = endm1_x[IW+OFF_W-1:OFF_W];
    dec_lo    = in_pos[OFF_W-1:0];
    dec_hi    = endm1_x[OFF_W-1:0];
    dec_grow  = 1'b0;
    case (in_cmd)
      CMD_NEXT_SET, CMD_NEXT_CLEAR: begin
        dec_last = IW'((len_x - CW'(1)) >> OFF_W);
        dec_hi   = 5'd31;
        if (pos_x >= len_x) begin
          dec_found = len_x[POS_W-1:0];
        end else begin
          dec_state = ST_WALK;
        end
      end
      CMD_SET_RANGE, CMD_TEST_RANGE: begin
        if (end_x < pos_x) begin
          dec_err = ERR_ORDER;
        end else if (end_x > CW'(MAX_BITS)) begin
          dec_err = ERR_CAPACITY;
        end else if (end_x == pos_x) begin
          dec_match = (in_cmd == CMD_TEST_RANGE);
        end else begin
          dec_state = ST_WALK;
        end
      end
      CMD_APPEND: begin
        dec_first = len_x[IW+OFF_W-1:OFF_W];
        dec_last  = app_last_x[IW+OFF_W-1:OFF_W];
        if (in_cnt > 6'd32 || app_end_x > CW'(MAX_BITS)) begin
          dec_err = ERR_CAPACITY;
        end else if (in_cnt != '0) begin
          dec_state = ST_PREP;
          dec_grow  = 1'b1;
        end
      end
      CMD_CLEAR: begin
        dec_state = ST_CLEAR;
      end
      default: begin
        dec_state = ST_DONE;
      end
    endcase
  end

  // word check on the read data of the walk
  logic                 want_clear;
  logic [OFF_W-1:0]     chk_lo, chk_hi;
  logic [WORD_BITS-1:0] chk_mask, chk_cur;
  logic                 chk_ok, chk_last, chk_hit, is_search, is_write;

  assign want_clear = (op == CMD_NEXT_CLEAR);
  assign is_search  = (op == CMD_NEXT_SET) || (op == CMD_NEXT_CLEAR);
  assign is_write   = (op == CMD_SET_RANGE) || (op == CMD_APPEND);
  assign chk_lo     = (chk_idx == first_idx) ? lo_bit : 5'd0;
  assign chk_hi     = (chk_idx == last_idx) ? hi_bit : 5'd31;
  assign chk_mask   = span_mask(chk_lo, chk_hi);
  assign chk_cur    = (ram_rd_data ^ {WORD_BITS{want_clear}}) & chk_mask;
  assign chk_ok     = (ram_rd_data & chk_mask) == (data_word[0] ? chk_mask : '0);
  assign chk_last   = chk_valid && (chk_idx == last_idx);
  assign chk_hit    = chk_valid && is_search && (chk_cur != '0);

  // found bit index, clamped to the length
  logic [CW-1:0] hit_x;

  assign hit_x = CW'({hit_idx, low_zero_count(hit_word)});

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = dec_state;
        end
      end
      ST_PREP: begin
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (chk_hit) begin
          state_next = ST_FOUND;
        end else if (chk_last) begin
          state_next = ST_DONE;
        end
      end
      ST_FOUND: begin
        state_next = ST_DONE;
      end
      ST_CLEAR: begin
        if (clr_idx == AW'(NUM_WORDS - 1)) begin
          state_next = clr_reply ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!out_valid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // handshake and ram controls
  always_comb begin
    s_tready    = (state == ST_IDLE);
    ram_rd_en   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = chk_idx[AW-1:0];
    ram_wr_data = ram_rd_data | chk_mask;
    case (state)
      ST_WALK: begin
        ram_rd_en = !rd_done && !chk_hit;
        ram_wr_en = chk_valid && is_write;
        if (op == CMD_APPEND) begin
          ram_wr_data = ram_rd_data |
                        ((chk_idx == first_idx) ? app_bits[WORD_BITS-1:0]
                                                : app_bits[2*WORD_BITS-1:WORD_BITS]);
        end
      end
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_idx;
        ram_wr_data = '0;
      end
      default: begin
        ram_rd_en = 1'b0;
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      length    <= '0;
      clr_idx   <= '0;
      clr_reply <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_IDLE && accept) begin
        clr_idx   <= '0;
        clr_reply <= 1'b1;
        if (dec_grow) begin
          length <= app_end_x[LEN_W-1:0];
        end
      end
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (state == ST_DONE && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          op        <= in_cmd;
          data_word <= in_data;
          first_idx <= dec_first;
          last_idx  <= dec_last;
          lo_bit    <= dec_lo;
          hi_bit    <= dec_hi;
          app_off   <= len_x[OFF_W-1:0];
          rev_bits  <= reverse_word(in_data) >> (6'd32 - in_cnt);
          rd_idx    <= dec_first;
          rd_done   <= 1'b0;
          chk_valid <= 1'b0;
          all_ok    <= 1'b1;
          res_found <= dec_found;
          res_match <= dec_match;
          res_err   <= dec_err;
        end
      end
      ST_PREP: begin
        app_bits <= {{WORD_BITS{1'b0}}, rev_bits} << app_off;
      end
      ST_WALK: begin
        // read stage
        chk_valid <= ram_rd_en;
        chk_idx   <= rd_idx;
        if (ram_rd_en) begin
          rd_idx <= rd_idx + IW'(1);
          if (rd_idx == last_idx) begin
            rd_done <= 1'b1;
          end
        end
        // check stage
        if (chk_valid) begin
          all_ok <= all_ok && chk_ok;
        end
        if (chk_hit) begin
          hit_idx  <= chk_idx;
          hit_word <= chk_cur;
        end else if (chk_last) begin
          if (is_search) begin
            res_found <= len_x[POS_W-1:0];
          end
          if (op == CMD_TEST_RANGE) begin
            res_match <= all_ok && chk_ok;
          end
        end
      end
      ST_FOUND: begin
        res_found <= (hit_x > len_x) ? len_x[POS_W-1:0] : hit_x[POS_W-1:0];
      end
      ST_DONE: begin
        if (!out_valid || m_tready) begin
          out_data <= {3'b000, len_x[POS_W-1:0], res_err, res_match, res_found};
        end
      end
      default: begin
        chk_valid <= 1'b0;
      end
    endcase
  end

  // word store
  bvse_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(NUM_WORDS)
  ) u_words (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(rd_idx[AW-1:0]),
    .rd_data(ram_rd_data)
  );

endmodule

`default_nettype wire

// ===== sim/bit_vector_scan_engine_unit_tb.sv =====
// self-checking testbench for the bit vector scan engine: directed, random and stall tests
`timescale 1ns / 1ps

module bit_vector_scan_engine_unit_tb;
  import bvse_pkg::*;

  localparam int MAX_BITS     = bvse_pkg::MAX_BITS_DEF;
  localparam int NUM_WORDS    = MAX_BITS / bvse_pkg::WORD_BITS;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 400;
  // command code outside the defined set, acts as a no-op
  localparam logic [CMD_W-1:0] CMD_UNDEFINED = 3'd7;

  typedef struct {
    logic [2:0]  cmd;
    logic [12:0] pos;
    logic [12:0] range_end;
    logic [31:0] data;
    logic [5:0]  count;
  } scan_cmd_t;

  typedef struct {
    logic [12:0] found;
    logic        match;
    logic [1:0]  err;
    logic [12:0] len;
  } scan_result_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  // position [12:0], range_end [25:13], data_word [57:26], bit_count [63:58]
  logic [IN_DATA_W-1:0] s_tdata;
  // command [2:0]
  logic [CMD_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  // found_index [12:0], range_match [13], error_code [15:14], bit_length [28:16]
  logic [OUT_DATA_W-1:0] m_tdata;

  // shadow copy of the bit store and its length
  logic [31:0]  shadow_words [NUM_WORDS];
  int unsigned  vec_len;
  scan_result_t pending_results[$];

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_cycles;
  int unsigned mismatch_count;
  int unsigned last_set_lo;
  int unsigned last_set_hi;

  bit_vector_scan_engine_unit dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // first index at or after pos holding the wanted value, clamped to the length
  function automatic int unsigned find_next(int unsigned pos, bit want_clear);
    int unsigned w;
    int unsigned lowest;
    int unsigned hit;
    logic [31:0] cur;
    if (pos >= vec_len) return vec_len;
    w   = pos / 32;
    cur = want_clear ? ~shadow_words[w] : shadow_words[w];
    cur &= 32'hFFFF_FFFF << (pos % 32);
    while (cur == 32'h0) begin
      w++;
      if (w >= NUM_WORDS) return vec_len;
      cur = want_clear ? ~shadow_words[w] : shadow_words[w];
    end
    lowest = 0;
    for (int b = 31; b >= 0; b--) begin
      if (cur[b]) lowest = b;
    end
    hit = w * 32 + lowest;
    return (hit > vec_len) ? vec_len : hit;
  endfunction

  // update the shadow store with one command and return its result
  function automatic scan_result_t apply_command(scan_cmd_t c);
    scan_result_t r;
    int unsigned  first_w;
    int unsigned  last_w;
    int unsigned  last_bit;
    int unsigned  lo;
    int unsigned  hi;
    logic [31:0]  m;
    logic         ok;
    r.found = '0;
    r.match = 1'b0;
    r.err   = ERR_OK;
    case (c.cmd)
      CMD_NEXT_SET, CMD_NEXT_CLEAR: begin
        r.found = 13'(find_next(c.pos, c.cmd == CMD_NEXT_CLEAR));
      end
      CMD_SET_RANGE, CMD_TEST_RANGE: begin
        if (c.range_end < c.pos) begin
          r.err = ERR_ORDER;
        end else if (c.range_end > MAX_BITS) begin
          r.err = ERR_CAPACITY;
        end else if (c.range_end == c.pos) begin
          r.match = (c.cmd == CMD_TEST_RANGE);
        end else begin
          last_bit = int'(c.range_end) - 1;
          first_w  = c.pos / 32;
          last_w   = last_bit / 32;
          ok       = 1'b1;
          for (int unsigned i = first_w; i <= last_w; i++) begin
            lo = (i == first_w) ? c.pos % 32 : 0;
            hi = (i == last_w) ? last_bit % 32 : 31;
            m  = (32'hFFFF_FFFF << lo) & (32'hFFFF_FFFF >> (31 - hi));
            if (c.cmd == CMD_SET_RANGE) begin
              shadow_words[i] |= m;
            end else if ((shadow_words[i] & m) != (c.data[0] ? m : 32'h0)) begin
              ok = 1'b0;
            end
          end
          if (c.cmd == CMD_TEST_RANGE) r.match = ok;
        end
      end
      CMD_APPEND: begin
        // most significant of the counted bits goes in first
        if (c.count > 32 || vec_len + c.count > MAX_BITS) begin
          r.err = ERR_CAPACITY;
        end else begin
          for (int k = int'(c.count); k > 0; k--) begin
            if (c.data[k-1]) shadow_words[vec_len / 32][vec_len % 32] = 1'b1;
            vec_len++;
          end
        end
      end
      CMD_CLEAR: begin
        foreach (shadow_words[j]) shadow_words[j] = '0;
      end
      default: begin
      end
    endcase
    r.len = 13'(vec_len);
    return r;
  endfunction

  function automatic scan_cmd_t make_cmd(logic [2:0] cmd, int unsigned pos,
                                         int unsigned range_end, logic [31:0] data,
                                         int unsigned count);
    scan_cmd_t c;
    c.cmd       = cmd;
    c.pos       = 13'(pos);
    c.range_end = 13'(range_end);
    c.data      = data;
    c.count     = 6'(count);
    return c;
  endfunction

  // mostly near the current length, sometimes anywhere in the store
  function automatic int unsigned random_position();
    int unsigned near_lim;
    near_lim = (vec_len + 64 > MAX_BITS) ? MAX_BITS : vec_len + 64;
    if ($urandom_range(99) < 85) return $urandom_range(near_lim);
    return $urandom_range(MAX_BITS);
  endfunction

  // short ranges dominate, long walks are rare
  function automatic int unsigned random_span();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) return $urandom_range(40);
    if (pick < 95) return $urandom_range(400, 41);
    return $urandom_range(MAX_BITS);
  endfunction

  function automatic scan_cmd_t random_scan_cmd();
    scan_cmd_t   c;
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    int unsigned span;
    pick = $urandom_range(99);
    c    = make_cmd(CMD_NEXT_SET, random_position(), 0, $urandom(), $urandom_range(32));
    lo   = c.pos;
    span = random_span();
    hi   = (lo + span > MAX_BITS) ? MAX_BITS : lo + span;
    if (pick < 18) begin
      c.cmd = CMD_NEXT_SET;
    end else if (pick < 34) begin
      c.cmd = CMD_NEXT_CLEAR;
    end else if (pick < 46) begin
      c.cmd       = CMD_SET_RANGE;
      c.range_end = 13'(hi);
      last_set_lo = lo;
      last_set_hi = hi;
    end else if (pick < 64) begin
      c.cmd = CMD_TEST_RANGE;
      // often probe a range that was just filled
      if ($urandom_range(99) < 40) begin
        c.pos       = 13'(last_set_lo);
        c.range_end = 13'(last_set_hi);
        c.data[0]   = ($urandom_range(3) != 0);
      end else begin
        c.range_end = 13'(hi);
      end
    end else if (pick < 85) begin
      c.cmd = CMD_APPEND;
    end else if (pick < 87) begin
      c.cmd = CMD_CLEAR;
    end else if (pick < 94) begin
      // end below start
      c.cmd       = ($urandom_range(1) != 0) ? CMD_SET_RANGE : CMD_TEST_RANGE;
      c.pos       = 13'($urandom_range(MAX_BITS, 1));
      c.range_end = 13'($urandom_range(int'(c.pos) - 1));
    end else begin
      // unstructured noise over all commands and the whole store range
      c.cmd       = 3'($urandom_range(CMD_CLEAR));
      c.pos       = 13'($urandom_range(MAX_BITS));
      c.range_end = 13'($urandom_range(MAX_BITS));
    end
    return c;
  endfunction

  // present one command, wait for its transfer, queue its expected result
  task automatic send_cmd(scan_cmd_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.cmd;
    s_tdata  <= {c.count, c.data, c.range_end, c.pos};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_command(c));
  endtask

  task automatic report_mismatch(string what, scan_result_t want_r, scan_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected found=%0d match=%0b err=%0d len=%0d",
               $time, what, want_r.found, want_r.match, want_r.err, want_r.len,
               ", got found=%0d match=%0b err=%0d len=%0d",
               got.found, got.match, got.err, got.len);
    end
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    scan_result_t got;
    scan_result_t want_r;
    if (!rst && m_tvalid && m_tready) begin
      got.found = m_tdata[12:0];
      got.match = m_tdata[13];
      got.err   = m_tdata[15:14];
      got.len   = m_tdata[28:16];
      if (pending_results.size() == 0) begin
        want_r = '{found: '0, match: 1'b0, err: '0, len: '0};
        report_mismatch("result with nothing pending", want_r, got);
      end else begin
        want_r = pending_results.pop_front();
        if (got.found !== want_r.found || got.match !== want_r.match ||
            got.err !== want_r.err || got.len !== want_r.len) begin
          report_mismatch("result mismatch", want_r, got);
        end
      end
    end
  end

  // result side ready, with random idling and long hold-offs
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // extremes of every field, every command and the corner cases
  task automatic test_directed();
    send_cmd(make_cmd(CMD_NEXT_SET, 0, 0, 32'h0, 0));
    send_cmd(make_cmd(CMD_APPEND, 0, 0, 32'h8000_0001, 32));
    send_cmd(make_cmd(CMD_APPEND, 0, 0, 32'hFFFF_FFFF, 0));
    send_cmd(make_cmd(CMD_APPEND, 0, 0, 32'h0000_0006, 5));
    send_cmd(make_cmd(CMD_NEXT_SET, 1, 0, 32'h0, 0));
    send_cmd(make_cmd(CMD_NEXT_CLEAR, 0, 0, 32'h0, 0));
    send_cmd(make_cmd(CMD_NEXT_CLEAR, MAX_BITS, MAX_BITS, 32'h0, 0));
    // ones past the length survive a later append of zeros
    send_cmd(make_cmd(CMD_SET_RANGE, 40, 100, 32'h0, 0));
    send_cmd(make_cmd(CMD_APPEND, 0, 0, 32'h0, 8));
    send_cmd(make_cmd(CMD_NEXT_CLEAR, 40, 0, 32'h0, 0));
    send_cmd(make_cmd(CMD_TEST_RANGE, 40, 45, 32'h1, 0));
    send_cmd(make_cmd(CMD_TEST_RANGE, 0, 32, 32'h0, 0));
    send_cmd(make_cmd(CMD_SET_RANGE, 50, 20, 32'h0, 0));
    send_cmd(make_cmd(CMD_TEST_RANGE, 7, 7, 32'h0, 0));
    send_cmd(make_cmd(CMD_SET_RANGE, 7, 7, 32'h0, 0));
    // ranges and appends beyond the store
    send_cmd(make_cmd(CMD_SET_RANGE, 4000, MAX_BITS + 1, 32'h0, 0));
    send_cmd(make_cmd(CMD_TEST_RANGE, 0, 8191, 32'h1, 0));
    send_cmd(make_cmd(CMD_APPEND, 0, 0, 32'hFFFF_FFFF, 63));
    send_cmd(make_cmd(CMD_UNDEFINED, 8191, 8191, 32'hFFFF_FFFF, 63));
    // ones set beyond the length are not found, the search returns the length
    send_cmd(make_cmd(CMD_CLEAR, 0, 0, 32'h0, 0));
    send_cmd(make_cmd(CMD_SET_RANGE, 3000, 3010, 32'h0, 0));
    send_cmd(make_cmd(CMD_NEXT_SET, 0, 0, 32'h0, 0));
    send_cmd(make_cmd(CMD_SET_RANGE, 0, MAX_BITS, 32'h0, 0));
    send_cmd(make_cmd(CMD_TEST_RANGE, 0, MAX_BITS, 32'h1, 0));
    send_cmd(make_cmd(CMD_NEXT_CLEAR, 0, 0, 32'h0, 0));
    send_cmd(make_cmd(CMD_CLEAR, 0, 0, 32'h0, 0));
    send_cmd(make_cmd(CMD_TEST_RANGE, 0, MAX_BITS, 32'h0, 0));
    last_set_lo = 0;
    last_set_hi = MAX_BITS;
  endtask

  task automatic test_random(int unsigned n_items, int unsigned tx_pct, int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n_items) send_cmd(random_scan_cmd());
  endtask

  // result side stalls for a long stretch while commands keep coming
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    s_tvalid <= 1'b0;
    @(negedge clk);
    hold_cycles = HOLD_CYCLES;
    @(posedge clk);
    repeat (12) send_cmd(random_scan_cmd());
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    m_tready       = 1'b0;
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    hold_cycles    = 0;
    mismatch_count = 0;
    vec_len        = 0;
    last_set_lo    = 0;
    last_set_hi    = 0;
    foreach (shadow_words[j]) shadow_words[j] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(520, 17, 70);
    test_backpressure();
    test_random(520, 70, 17);
    test_random(500, 0, 0);

    // drain
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("bit_vector_scan_engine_unit_tb passed");
    end else begin
      $display("bit_vector_scan_engine_unit_tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("bit_vector_scan_engine_unit_tb failed");
    $finish;
  end

endmodule
